// File: rtl/core/sui_pkg.sv
// Shared types and constants for the sorted unique insert table.
`default_nettype none
package sui_pkg;

  localparam int VALUE_BITS      = 16;
  localparam int ENTRY_BITS      = VALUE_BITS - 1;
  localparam int POS_BITS        = 8;
  localparam int STATUS_BITS     = 3;
  localparam int COUNT_OUT_BITS  = 7;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_READ   = 1'b1
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_NONPOS = 3'd2,
    ST_FULL   = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  typedef struct packed {
    kind_t                        kind;
    logic signed [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]          position;
  } in_item_t;

  typedef struct packed {
    status_t                      status;
    logic signed [VALUE_BITS-1:0] entry_out;
    logic [COUNT_OUT_BITS-1:0]    entry_count;
  } out_item_t;

  // Token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                  active;
    logic                  done;
    kind_t                 kind;
    logic                  carrying;
    status_t               status;
    logic [ENTRY_BITS-1:0] val;
    logic [POS_BITS-1:0]   position;
    logic [ENTRY_BITS-1:0] rd_data;
  } tok_t;

endpackage
`default_nettype wire

// File: rtl/core/sorted_unique_insert_table.sv
// Top level of the sorted unique insert table: controller and the cell chain.
// Each accepted item becomes a token that walks a chain of CAPACITY cells, one cell per
// cycle. With the output register free, its result passes from the injection register
// through the cell registers and the result register into the output register, and the
// next item is taken the cycle after that; no new item is accepted while one is in the
// chain. The next item is taken even while that result still waits on a stalled output,
// but a finished result that finds the output register still occupied waits for it, which
// delays the next acceptance by as long. Inserts keep the table in ascending order by
// swapping the new value into its slot and rippling larger entries up as the token
// passes; reads pick the entry out as the token passes the matching slot.
// Entry storage is not cleared by reset; only slots below the entry count are ever read.
`default_nettype none
module sorted_unique_insert_table #(
  parameter int CAPACITY = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sui_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sui_pkg::out_item_t     out_item
);
  import sui_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t          state_r, state_nxt;
  tok_t            inj_r, inj_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  out_item_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  tok_t                  chain_tok [CAPACITY+1];
  tok_t                  exit_tok;
  logic                  full;
  logic                  nonpos;
  status_t               fin_status;
  logic [VALUE_BITS-1:0] fin_entry;
  logic [CW-1:0]         count_fin;

  assign full     = (count_r == CW'(CAPACITY));
  assign in_stall = (state_r != S_IDLE);
  assign nonpos   = in_item.value[VALUE_BITS-1] || (in_item.value == '0);

  assign chain_tok[0] = inj_r;
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    sui_cell #(
      .IDX (gi),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .count   (count_r),
      .full    (full),
      .tok_in  (chain_tok[gi]),
      .tok_out (chain_tok[gi+1])
    );
  end
  assign exit_tok = chain_tok[CAPACITY];

  // A token that reaches the end unresolved found no slot to act on.
  always_comb begin
    fin_status = exit_tok.status;
    fin_entry  = '0;
    count_fin  = count_r;
    if (exit_tok.kind == KIND_READ) begin
      if (exit_tok.done) begin
        fin_entry = VALUE_BITS'(exit_tok.rd_data);
      end else begin
        fin_status = ST_RANGE;
        fin_entry  = '1;
      end
    end else begin
      if (!exit_tok.done) begin
        fin_status = ST_FULL;
      end else if (exit_tok.status == ST_OK) begin
        count_fin = CW'(count_r + 1'b1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    inj_nxt       = inj_r;
    inj_nxt.active = 1'b0;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          inj_nxt.active   = 1'b1;
          inj_nxt.kind     = in_item.kind;
          inj_nxt.val      = in_item.value[ENTRY_BITS-1:0];
          inj_nxt.position = in_item.position;
          inj_nxt.carrying = 1'b0;
          inj_nxt.rd_data  = '0;
          inj_nxt.status   = ST_OK;
          inj_nxt.done     = 1'b0;
          if (in_item.kind == KIND_INSERT && nonpos) begin
            inj_nxt.status = ST_NONPOS;
            inj_nxt.done   = 1'b1;
          end
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (exit_tok.active) begin
          res_nxt.status      = fin_status;
          res_nxt.entry_out   = fin_entry;
          res_nxt.entry_count = COUNT_OUT_BITS'(count_fin);
          count_nxt           = count_fin;
          state_nxt           = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inj_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inj_r       <= inj_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      res_r       <= res_nxt;
      out_item_r  <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// File: rtl/core/sui_cell.sv
// One table slot: holds an entry and acts on the token passing through it.
`default_nettype none
module sui_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [CW-1:0] count,
  input  wire logic          full,
  input  wire sui_pkg::tok_t tok_in,
  output sui_pkg::tok_t      tok_out
);
  import sui_pkg::*;

  localparam int IW = (CW > POS_BITS) ? CW : POS_BITS;
  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [IW-1:0] IDX_IW = IW'(IDX);

  logic [ENTRY_BITS-1:0] entry_r;
  logic [ENTRY_BITS-1:0] entry_nxt;
  tok_t                  tok_r;
  tok_t                  tok_nxt;
  logic                  in_range;
  logic                  pos_hit;

  assign in_range = (IDX_C < count);
  assign pos_hit  = (IW'(tok_in.position) == IDX_IW);

  always_comb begin
    tok_nxt   = tok_in;
    entry_nxt = entry_r;
    if (tok_in.active && !tok_in.done) begin
      if (tok_in.kind == KIND_READ) begin
        if (in_range && pos_hit) begin
          tok_nxt.rd_data = entry_r;
          tok_nxt.status  = ST_OK;
          tok_nxt.done    = 1'b1;
        end
      end else if (tok_in.carrying) begin
        // Ripple the displaced entry upward; the first slot past the count ends it.
        entry_nxt = tok_in.val;
        if (in_range) begin
          tok_nxt.val = entry_r;
        end else begin
          tok_nxt.status = ST_OK;
          tok_nxt.done   = 1'b1;
        end
      end else if (in_range) begin
        if (entry_r == tok_in.val) begin
          tok_nxt.status = ST_DUP;
          tok_nxt.done   = 1'b1;
        end else if (entry_r > tok_in.val) begin
          // Every later entry is larger too, so no duplicate can follow.
          if (full) begin
            tok_nxt.status = ST_FULL;
            tok_nxt.done   = 1'b1;
          end else begin
            entry_nxt        = tok_in.val;
            tok_nxt.val      = entry_r;
            tok_nxt.carrying = 1'b1;
          end
        end
      end else begin
        // First free slot: the new value is the largest so far.
        entry_nxt      = tok_in.val;
        tok_nxt.status = ST_OK;
        tok_nxt.done   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign tok_out = tok_r;

endmodule
`default_nettype wire

// File: rtl/core/sui_checker.sv
// Port-level checks for the sorted unique insert table, bound to the top level.
`default_nettype none
module sui_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire sui_pkg::out_item_t out_item
);
  import sui_pkg::*;

  // Reset leaves no result pending and the input open.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  // An accepted item holds the input off while it is processed.
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an item was accepted");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_range_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_RANGE |-> out_item.entry_out == '1)
    else $error("out of range read did not return -1");

  a_insert_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_DUP || out_item.status == ST_NONPOS ||
                  out_item.status == ST_FULL) |-> out_item.entry_out == '0)
    else $error("insert result carries a nonzero entry");

endmodule

bind sorted_unique_insert_table sui_checker u_sui_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
